/* hw/rtl/rpa_pkg.sv */
// shared types, register indexes and sine table generator for the point rotator
// no dependencies; used by the matrix setup unit, the datapath and the top level
`timescale 1ns / 1ps

package rpa_pkg;

	localparam int ANGLE_BITS_DEF = 12;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int COEF_W         = 16;
	localparam int COORD_W        = 32;

	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANGLE   = 3'd0,
		CFG_AXIS_X  = 3'd1,
		CFG_AXIS_Y  = 3'd2,
		CFG_AXIS_Z  = 3'd3,
		CFG_PIVOT_X = 3'd4,
		CFG_PIVOT_Y = 3'd5,
		CFG_PIVOT_Z = 3'd6
	} cfg_reg_t;

	// matrix in row-major order, pivot, and setup status
	typedef struct packed {
		logic [8:0][COEF_W-1:0]  m;
		logic [2:0][COORD_W-1:0] pivot;
		logic                    busy;
	} xform_t;

	// (a*b) >> s on the full 128-bit product
	function automatic logic [63:0] mulshr(input logic [63:0] a, input logic [63:0] b,
		input int unsigned s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> s;
		return p[63:0];
	endfunction

	// unsigned long division by shift and subtract, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// round(16384*sin(2*pi*q/2^ab)) for one quarter-wave entry, elaboration only
	function automatic logic [15:0] sine_q14(input int unsigned q, input int unsigned ab);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] dv;
		logic        done;
		x    = mulshr(HALF_PI_Q60, 64'(q), ab - 2);
		x2   = mulshr(x, x, 60);
		term = x;
		sum  = x;
		done = 1'b0;
		for (int unsigned n = 1; n < 40; n++) begin
			if (!done) begin
				dv   = 64'((2 * n) * (2 * n + 1));
				term = udiv64(mulshr(term, x2, 60), dv);
				if (term == 64'd0) begin
					done = 1'b1;
				end else if (n[0]) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		return 16'((sum + (64'd1 << 45)) >> 46);
	endfunction

endpackage

/* hw/rtl/rpa_if.sv */
// valid/ready channel interfaces for points in and rotated points out
// no dependencies
`timescale 1ns / 1ps

interface rpa_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;

	modport source (output valid, output point_x, output point_y, output point_z, input ready);
	modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface rpa_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] rotated_x;
	logic signed [31:0] rotated_y;
	logic signed [31:0] rotated_z;
	logic               clipped;

	modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
		output clipped, input ready);
	modport sink (input valid, input rotated_x, input rotated_y, input rotated_z,
		input clipped, output ready);
endinterface

/* hw/rtl/rotate_point_about_axis_top.sv */
// top level of the axis-angle point rotator
// instantiates rpa_matrix and rpa_datapath; uses rpa_pkg and the channel interfaces
`timescale 1ns / 1ps

// usage
//   points:  valid/ready channel, one q16.16 point (x, y, z) per transfer
//   results: valid/ready channel, rotated point plus a clipped flag per transfer
//   cfg:     write port; cfg_index selects angle, axis x/y/z, pivot x/y/z
// pipeline: a point passes stage registers s1 to s4 before its result is presented
// throughput: one point per cycle, set by the four-stage datapath, while the matrix
//   unit is idle and results.ready does not hold the pipeline
// setup: after reset and after every register write the matrix unit makes two
//   sine rom reads, then runs nine entries through a shared multiply/round unit;
//   points.ready stays low until the last entry is written
// reset: angle 0, axis (1.0, 0, 0), pivot at the origin, pipeline empty
// stall: when results.ready is low each stage holds its point; empty stages
//   behind the output keep filling, so input is still taken until the
//   pipeline is full. nothing is dropped or repeated
// registers are written by the user only while no point is in flight; not enforced

module rotate_point_about_axis_top #(
	parameter int ANGLE_BITS = rpa_pkg::ANGLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rpa_point_if.sink                      points,
	rpa_result_if.source                   results
);
	import rpa_pkg::*;

	xform_t xform;

	rpa_matrix #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.xform     (xform)
	);

	rpa_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.xform   (xform),
		.points  (points),
		.results (results)
	);

endmodule

/* hw/rtl/rpa_matrix.sv */
// configuration registers and rotation matrix setup sequencer
// sine rom, one entry per cycle through a shared three-stage unit; uses rpa_pkg
`timescale 1ns / 1ps

module rpa_matrix #(
	parameter int ANGLE_BITS = rpa_pkg::ANGLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [rpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rpa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output rpa_pkg::xform_t                  xform
);
	import rpa_pkg::*;

	localparam int QUARTER = 1 << (ANGLE_BITS - 2);
	localparam int IDX_W   = ANGLE_BITS - 1;

	localparam logic [3:0] STEP_SIN  = 4'd0;
	localparam logic [3:0] STEP_SCAP = 4'd1;
	localparam logic [3:0] STEP_CCAP = 4'd2;
	localparam logic [3:0] STEP_ENT0 = 4'd3;
	localparam logic [3:0] STEP_ENT8 = 4'd11;
	localparam logic [3:0] STEP_LAST = 4'd13;

	// quarter-wave sine table
	logic [15:0] rom_w [QUARTER+1];

	for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
		localparam logic [15:0] VAL = sine_q14(k, ANGLE_BITS);
		assign rom_w[k] = VAL;
	end

	logic [ANGLE_BITS-1:0] angle_q;
	logic signed [15:0]    axis_q [3];
	logic [31:0]           pivot_q [3];
	logic                  busy_q;
	logic [3:0]            step_q;

	logic [ANGLE_BITS-1:0] cos_ang;
	logic [ANGLE_BITS-1:0] rd_ang;
	logic [IDX_W-1:0]      rd_r;
	logic [IDX_W-1:0]      rd_idx;
	logic [15:0]           rom_q;
	logic                  neg_q;
	logic signed [15:0]    sv;
	logic signed [15:0]    s_q;
	logic signed [15:0]    c_q;
	logic signed [16:0]    t_q;

	logic [3:0]            ent;
	logic                  issue;
	logic signed [15:0]    ua;
	logic signed [15:0]    ub;
	logic signed [15:0]    uk;
	logic                  sneg;
	logic                  dg;
	logic signed [31:0]    usp;

	logic                  v1_q;
	logic [3:0]            e1_q;
	logic signed [31:0]    uu1_q;
	logic signed [31:0]    us1_q;
	logic                  dg1_q;

	logic                  v2_q;
	logic [3:0]            e2_q;
	logic signed [48:0]    uut2_q;
	logic signed [31:0]    us2_q;
	logic signed [15:0]    dg2_q;

	logic signed [48:0]    q42;
	logic signed [20:0]    ev;
	logic signed [15:0]    esat;
	logic signed [15:0]    m_q [9];

	// rom address: sine of the angle, then cosine as sine a quarter turn on
	assign cos_ang = angle_q + ANGLE_BITS'(QUARTER);
	assign rd_ang  = (step_q == STEP_SIN) ? angle_q : cos_ang;
	assign rd_r    = {1'b0, rd_ang[ANGLE_BITS-3:0]};
	assign rd_idx  = rd_ang[ANGLE_BITS-2] ? (IDX_W'(QUARTER) - rd_r) : rd_r;
	assign sv      = neg_q ? -$signed(rom_q) : $signed(rom_q);

	assign ent   = step_q - STEP_ENT0;
	assign issue = busy_q && (step_q >= STEP_ENT0) && (step_q <= STEP_ENT8);

	always_comb begin
		ua   = axis_q[0];
		ub   = axis_q[0];
		uk   = axis_q[0];
		sneg = 1'b0;
		dg   = 1'b0;
		case (ent)
			4'd0: begin
				ua = axis_q[0]; ub = axis_q[0]; uk = 16'sd0; dg = 1'b1;
			end
			4'd1: begin
				ua = axis_q[0]; ub = axis_q[1]; uk = axis_q[2]; sneg = 1'b1;
			end
			4'd2: begin
				ua = axis_q[0]; ub = axis_q[2]; uk = axis_q[1];
			end
			4'd3: begin
				ua = axis_q[1]; ub = axis_q[0]; uk = axis_q[2];
			end
			4'd4: begin
				ua = axis_q[1]; ub = axis_q[1]; uk = 16'sd0; dg = 1'b1;
			end
			4'd5: begin
				ua = axis_q[1]; ub = axis_q[2]; uk = axis_q[0]; sneg = 1'b1;
			end
			4'd6: begin
				ua = axis_q[2]; ub = axis_q[0]; uk = axis_q[1]; sneg = 1'b1;
			end
			4'd7: begin
				ua = axis_q[2]; ub = axis_q[1]; uk = axis_q[0];
			end
			4'd8: begin
				ua = axis_q[2]; ub = axis_q[2]; uk = 16'sd0; dg = 1'b1;
			end
			default: begin
				ua = 16'sd0; ub = 16'sd0; uk = 16'sd0;
			end
		endcase
	end

	assign usp = 32'(uk) * 32'(s_q);

	// entry: c*2^28 + uu*t + us*2^14, rounded half up to q1.14 and saturated
	always_comb begin
		q42 = ({{33{dg2_q[15]}}, dg2_q} <<< 28) + uut2_q + ({{17{us2_q[31]}}, us2_q} <<< 14);
		q42 = q42 + (49'sd1 <<< 27);
		ev  = q42[48:28];
		if (ev > 21'sd32767) begin
			esat = 16'sd32767;
		end else if (ev < -21'sd32768) begin
			esat = -16'sd32768;
		end else begin
			esat = ev[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q    <= '0;
			axis_q[0]  <= 16'sd16384;
			axis_q[1]  <= 16'sd0;
			axis_q[2]  <= 16'sd0;
			pivot_q[0] <= '0;
			pivot_q[1] <= '0;
			pivot_q[2] <= '0;
			busy_q     <= 1'b1;
			step_q     <= STEP_SIN;
			v1_q       <= 1'b0;
			v2_q       <= 1'b0;
		end else begin
			v1_q <= issue;
			v2_q <= v1_q;
			if (cfg_wen) begin
				busy_q <= 1'b1;
				step_q <= STEP_SIN;
				case (cfg_reg_t'(cfg_index))
					CFG_ANGLE:   angle_q    <= cfg_wdata[ANGLE_BITS-1:0];
					CFG_AXIS_X:  axis_q[0]  <= cfg_wdata[15:0];
					CFG_AXIS_Y:  axis_q[1]  <= cfg_wdata[15:0];
					CFG_AXIS_Z:  axis_q[2]  <= cfg_wdata[15:0];
					CFG_PIVOT_X: pivot_q[0] <= cfg_wdata[31:0];
					CFG_PIVOT_Y: pivot_q[1] <= cfg_wdata[31:0];
					CFG_PIVOT_Z: pivot_q[2] <= cfg_wdata[31:0];
					default: ;
				endcase
			end else if (busy_q) begin
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= rom_w[rd_idx];
		neg_q <= rd_ang[ANGLE_BITS-1];
		if (busy_q && step_q == STEP_SCAP) begin
			s_q <= sv;
		end
		if (busy_q && step_q == STEP_CCAP) begin
			c_q <= sv;
			t_q <= 17'sd16384 - {sv[15], sv};
		end
		e1_q   <= ent;
		uu1_q  <= 32'(ua) * 32'(ub);
		us1_q  <= sneg ? -usp : usp;
		dg1_q  <= dg;
		e2_q   <= e1_q;
		uut2_q <= 49'(uu1_q) * 49'(t_q);
		us2_q  <= us1_q;
		dg2_q  <= dg1_q ? c_q : 16'sd0;
		if (v2_q) begin
			m_q[e2_q] <= esat;
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			xform.m[k] = m_q[k];
		end
		for (int k = 0; k < 3; k++) begin
			xform.pivot[k] = pivot_q[k];
		end
		xform.busy = busy_q;
	end

endmodule

/* hw/rtl/rpa_datapath.sv */
// four-stage point pipeline: pivot subtract, matrix products, row sums, pivot add
// and saturation into the output register; uses rpa_pkg and the channel interfaces
`timescale 1ns / 1ps

module rpa_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  rpa_pkg::xform_t  xform,
	rpa_point_if.sink        points,
	rpa_result_if.source     results
);
	import rpa_pkg::*;

	logic rdy1, rdy2, rdy3, rdy4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic take;

	logic signed [32:0] d_s1 [3];
	logic signed [48:0] prod_s2 [3][3];
	logic signed [36:0] r_s3 [3];
	logic signed [31:0] out_s4 [3];
	logic               clip_s4;

	logic signed [31:0] pin [3];
	logic signed [31:0] piv [3];
	logic signed [48:0] prod [3][3];
	logic signed [50:0] acc [3];
	logic signed [36:0] rsh [3];
	logic signed [37:0] sum [3];
	logic signed [31:0] sat [3];
	logic [2:0]         ovf;

	// each stage loads when it is empty or its successor moves
	assign rdy4 = !v_s4 || results.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign points.ready = rdy1 && !xform.busy;
	assign take         = points.valid && points.ready;

	assign pin[0] = points.point_x;
	assign pin[1] = points.point_y;
	assign pin[2] = points.point_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			piv[i] = $signed(xform.pivot[i]);
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod[i][j] = 49'($signed(xform.m[3*i+j])) * 49'(d_s1[j]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			acc[i] = {{2{prod_s2[i][0][48]}}, prod_s2[i][0]}
				+ {{2{prod_s2[i][1][48]}}, prod_s2[i][1]}
				+ {{2{prod_s2[i][2][48]}}, prod_s2[i][2]}
				+ 51'sd8192;
			rsh[i] = acc[i][50:14];
			sum[i] = {r_s3[i][36], r_s3[i]} + {{6{piv[i][31]}}, piv[i]};
			ovf[i] = (sum[i][37:31] != {7{sum[i][37]}});
			if (!ovf[i]) begin
				sat[i] = sum[i][31:0];
			end else if (sum[i][37]) begin
				sat[i] = 32'sh8000_0000;
			end else begin
				sat[i] = 32'sh7FFF_FFFF;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= take;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= {pin[i][31], pin[i]} - {piv[i][31], piv[i]};
			end
		end
		if (rdy2 && v_s1) begin
			prod_s2 <= prod;
		end
		if (rdy3 && v_s2) begin
			r_s3 <= rsh;
		end
		if (rdy4 && v_s3) begin
			out_s4  <= sat;
			clip_s4 <= |ovf;
		end
	end

	assign results.valid     = v_s4;
	assign results.rotated_x = out_s4[0];
	assign results.rotated_y = out_s4[1];
	assign results.rotated_z = out_s4[2];
	assign results.clipped   = clip_s4;

endmodule
